// ----- src/i32div_pkg.sv -----
package i32div_pkg;

	localparam int unsigned DATA_WIDTH = 32;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [1:0] {
		OP_SDIV = 2'd0,
		OP_SREM = 2'd1,
		OP_UDIV = 2'd2,
		OP_UREM = 2'd3
	} op_t;

	typedef struct packed {
		word_t dividend;
		word_t divisor;
		op_t   opcode;
	} req_t;

	typedef struct packed {
		word_t result;
		logic  div_by_zero;
	} rsp_t;

	// One slot of the divide pipeline: partial remainder, dividend bits that
	// shift out at the top while quotient bits shift in at the bottom.
	typedef struct packed {
		word_t rem;
		word_t num;
		word_t den;
		logic  neg_q;
		logic  neg_r;
		logic  sel_rem;
		logic  dbz;
	} stage_t;

endpackage

// ----- src/i32div_pre.sv -----
module i32div_pre (
	input  i32div_pkg::req_t   req,
	output i32div_pkg::stage_t stg
);
	import i32div_pkg::*;

	logic  is_signed;
	logic  sel_rem;
	logic  na;
	logic  nb;
	word_t ma;
	word_t mb;

	always_comb begin
		unique case (req.opcode)
			OP_SDIV: begin
				is_signed = 1'b1;
				sel_rem   = 1'b0;
			end
			OP_SREM: begin
				is_signed = 1'b1;
				sel_rem   = 1'b1;
			end
			OP_UDIV: begin
				is_signed = 1'b0;
				sel_rem   = 1'b0;
			end
			OP_UREM: begin
				is_signed = 1'b0;
				sel_rem   = 1'b1;
			end
			default: begin
				is_signed = 1'b0;
				sel_rem   = 1'b0;
			end
		endcase
	end

	// Take magnitudes in signed modes; fix signs at the end of the pipe.
	assign na = is_signed & req.dividend[DATA_WIDTH-1];
	assign nb = is_signed & req.divisor[DATA_WIDTH-1];
	assign ma = na ? word_t'(-req.dividend) : req.dividend;
	assign mb = nb ? word_t'(-req.divisor) : req.divisor;

	always_comb begin
		stg.rem     = '0;
		stg.num     = ma;
		stg.den     = mb;
		stg.neg_q   = na ^ nb;
		stg.neg_r   = na;
		stg.sel_rem = sel_rem;
		stg.dbz     = (req.divisor == '0);
	end

endmodule

// ----- src/i32div_step.sv -----
module i32div_step (
	input  i32div_pkg::stage_t stg_in,
	output i32div_pkg::stage_t stg_out
);
	import i32div_pkg::*;

	logic [DATA_WIDTH:0] full;
	logic [DATA_WIDTH:0] diff;
	logic                qbit;

	// Shift the next dividend bit in; the old top bit of rem is the extra
	// bit of the wide partial remainder.
	assign full = {stg_in.rem, stg_in.num[DATA_WIDTH-1]};
	assign diff = full - {1'b0, stg_in.den};
	assign qbit = ~diff[DATA_WIDTH];

	always_comb begin
		stg_out     = stg_in;
		stg_out.rem = qbit ? diff[DATA_WIDTH-1:0] : full[DATA_WIDTH-1:0];
		stg_out.num = {stg_in.num[DATA_WIDTH-2:0], qbit};
	end

endmodule

// ----- src/i32div_post.sv -----
module i32div_post (
	input  i32div_pkg::stage_t stg,
	output i32div_pkg::rsp_t   rsp
);
	import i32div_pkg::*;

	word_t mag;
	logic  neg;

	assign mag = stg.sel_rem ? stg.rem : stg.num;
	assign neg = stg.sel_rem ? stg.neg_r : stg.neg_q;

	always_comb begin
		if (stg.dbz) begin
			rsp.result = '0;
		end else begin
			rsp.result = neg ? word_t'(-mag) : mag;
		end
		rsp.div_by_zero = stg.dbz;
	end

endmodule

// ----- src/int32_divider.sv -----
// Channel  | Ports              | Transaction taken when
// ---------+--------------------+-----------------------------------------
// command  | start, busy, req   | rising edge with start high, busy low
// result   | done, rsp          | rising edge ending the cycle done is high
//
// One transaction enters per cycle; busy is never raised.
// On the way from the accepting edge to done, the operand-magnitude
// register loads at the accepting edge, then one restoring step per
// quotient bit, then one sign-fix/select stage into the output register.
// Reset clears all valid bits and done; the data path is not reset.
// The result side cannot stall, so the pipe advances every cycle.
module int32_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  i32div_pkg::req_t  req,
	output logic              done,
	output i32div_pkg::rsp_t  rsp
);
	import i32div_pkg::*;

	// pipe_s[0] holds operand magnitudes, pipe_s[k] holds k quotient bits.
	logic   pipe_valid_s [DATA_WIDTH+1];
	stage_t pipe_s       [DATA_WIDTH+1];
	stage_t step_d       [DATA_WIDTH];
	stage_t pre_d;
	rsp_t   post_d;
	logic   done_q;
	rsp_t   rsp_q;

	// Nothing ever holds the pipe, so a new command is always welcome.
	assign busy = 1'b0;

	// Entry: sign handling and divide-by-zero detection.
	i32div_pre u_pre (
		.req (req),
		.stg (pre_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_s[0] <= 1'b0;
		end else begin
			pipe_valid_s[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= pre_d;
	end

	// One restoring step per stage; valid travels alongside.
	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
		i32div_step u_step (
			.stg_in  (pipe_s[k]),
			.stg_out (step_d[k])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_valid_s[k+1] <= 1'b0;
			end else begin
				pipe_valid_s[k+1] <= pipe_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			pipe_s[k+1] <= step_d[k];
		end
	end

	// Exit: pick quotient or remainder, restore the sign, force zero on
	// a zero divisor.
	i32div_post u_post (
		.stg (pipe_s[DATA_WIDTH]),
		.rsp (post_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pipe_valid_s[DATA_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= post_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##(DATA_WIDTH+1) done)
		else $error("accepted command produced no result on time");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, DATA_WIDTH+2))
		else $error("result without a matching command");

	a_dbz_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.div_by_zero == ($past(req.divisor, DATA_WIDTH+2) == '0)))
		else $error("divide-by-zero flag does not match divisor");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.div_by_zero) |-> (rsp.result == '0))
		else $error("nonzero result on divide by zero");
`endif

endmodule
